### src/ring_identifier_arithmetic_macros.svh
// Assertion macros shared by the ring identifier arithmetic RTL.
// Each macro expects a clk and rst in scope at the point of use.
`ifndef RING_IDENTIFIER_ARITHMETIC_MACROS_SVH
`define RING_IDENTIFIER_ARITHMETIC_MACROS_SVH

// Same-cycle implication.
`define RIA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define RIA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### src/ria_pkg.sv
// Types, constants and helper functions of the ring identifier arithmetic unit.
// No dependencies; every other file but the macro header imports this package.
package ria_pkg;

  localparam int ID_BITS    = 64;
  localparam int DIGIT_BITS = 4;
  localparam int DIGITS     = ID_BITS / DIGIT_BITS;
  localparam int CNT_BITS   = $clog2(DIGITS + 1);
  localparam int NUM_BITS   = 23;
  localparam int ACT_BITS   = 3;
  // one dividend bit per stage
  localparam int DIV_STAGES = ID_BITS;

  typedef logic [ID_BITS-1:0]  id_t;
  typedef logic [NUM_BITS-1:0] num_t;

  typedef enum logic [ACT_BITS-1:0] {
    ACT_AHEAD   = 3'd0,
    ACT_CLOSER  = 3'd1,
    ACT_BETWEEN = 3'd2,
    ACT_HALFWAY = 3'd3,
    ACT_PREFIX  = 3'd4,
    ACT_MODULO  = 3'd5
  } action_t;

  typedef struct packed {
    logic flag;
    id_t  id;
    num_t num;
  } res_t;

  // One restoring step: shift in a dividend bit, subtract the divisor if it fits.
  function automatic num_t div_step(num_t rem, logic bit_in, num_t divisor);
    logic [NUM_BITS:0] t;
    logic [NUM_BITS:0] d;
    begin
      t = {rem, bit_in};
      d = {1'b0, divisor};
      if (t >= d) begin
        t = t - d;
      end
      return t[NUM_BITS-1:0];
    end
  endfunction

endpackage

### src/ria_req_if.sv
// Request channel of the ring identifier arithmetic unit.
// Depends on ria_pkg.
interface ria_req_if;
  import ria_pkg::*;

  logic                valid;
  logic                ready;
  logic [ACT_BITS-1:0] action;
  id_t                 id_a;
  id_t                 id_b;
  id_t                 id_c;
  num_t                modulus;

  modport source (output valid, action, id_a, id_b, id_c, modulus, input ready);
  modport sink   (input valid, action, id_a, id_b, id_c, modulus, output ready);
endinterface

### src/ria_res_if.sv
// Result channel of the ring identifier arithmetic unit.
// Depends on ria_pkg.
interface ria_res_if;
  import ria_pkg::*;

  logic valid;
  logic ready;
  logic answer_flag;
  id_t  answer_id;
  num_t answer_number;

  modport source (output valid, answer_flag, answer_id, answer_number, input ready);
  modport sink   (input valid, answer_flag, answer_id, answer_number, output ready);
endinterface

### src/ria_ring_ops.sv
// Three-stage datapath for the compare, halfway and prefix actions.
// Depends on ria_pkg; advances only when en is high.
module ria_ring_ops (
  input  logic                         clk,
  input  logic                         en,
  input  logic [ria_pkg::ACT_BITS-1:0] action,
  input  ria_pkg::id_t                 id_a,
  input  ria_pkg::id_t                 id_b,
  input  ria_pkg::id_t                 id_c,
  output ria_pkg::res_t                res
);
  import ria_pkg::*;

  // stage 0: ring differences and digit mismatches
  logic [ACT_BITS-1:0] act0;
  id_t                 a0, dab, dba, dac, dca, dbc, dcb;
  logic [DIGITS-1:0]   mis0;

  // stage 1: orderings, distances, midpoint, prefix length
  logic [ACT_BITS-1:0] act1;
  logic                ahead_ab, ahead_cb, ahead_ca;
  id_t                 dist_ac, dist_bc, mid;
  logic [CNT_BITS-1:0] pfx;

  logic [DIGITS-1:0]   mis_next;
  logic [CNT_BITS-1:0] pfx_next;
  logic                found;
  res_t                res_next;

  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      mis_next[i] = |((id_a[ID_BITS-1-DIGIT_BITS*i -: DIGIT_BITS]) ^
                      (id_b[ID_BITS-1-DIGIT_BITS*i -: DIGIT_BITS]));
    end
  end

  // digit 0 is the most significant; stop at the first mismatch
  always_comb begin
    pfx_next = CNT_BITS'(DIGITS);
    found    = 1'b0;
    for (int i = 0; i < DIGITS; i++) begin
      if (mis0[i] && !found) begin
        pfx_next = CNT_BITS'(i);
        found    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      act0 <= action;
      a0   <= id_a;
      dab  <= id_a - id_b;
      dba  <= id_b - id_a;
      dac  <= id_a - id_c;
      dca  <= id_c - id_a;
      dbc  <= id_b - id_c;
      dcb  <= id_c - id_b;
      mis0 <= mis_next;

      act1     <= act0;
      ahead_ab <= dab < dba;
      ahead_cb <= dcb < dbc;
      ahead_ca <= dca < dac;
      dist_ac  <= (dac <= dca) ? dac : dca;
      dist_bc  <= (dbc <= dcb) ? dbc : dcb;
      mid      <= a0 + (dba >> 1);
      pfx      <= pfx_next;

      res <= res_next;
    end
  end

  always_comb begin
    res_next = '0;
    case (act1)
      ACT_AHEAD:   res_next.flag = ahead_ab;
      ACT_CLOSER:  res_next.flag = dist_ac < dist_bc;
      ACT_BETWEEN: res_next.flag = (ahead_cb && ahead_ab && ahead_ca) ||
                                   (!ahead_cb && (ahead_ca || ahead_ab));
      ACT_HALFWAY: res_next.id   = mid;
      ACT_PREFIX:  res_next.num  = NUM_BITS'(pfx);
      default:     res_next      = '0;
    endcase
  end

endmodule

### src/ring_identifier_arithmetic.sv
// Ring identifier arithmetic unit: six actions on 64-bit ring identifiers.
// Depends on ria_pkg, ria_req_if, ria_res_if, ria_ring_ops and the macro header.
//
// Usage:
//   req carries one request per handshake (action, id_a, id_b, id_c, modulus);
//   rsp returns exactly one result per request, in order.
//   A request is taken at a clock edge where valid and ready are both high.
// Path: a result passes through the 64 remainder stages, the first loaded
//   at the accepting edge, and then through the output register.
// Throughput: one request per cycle unless rsp stalls. The rate is set by the
//   remainder pipeline, which resolves one dividend bit in each of its 64
//   stages; the compare, midpoint and prefix work finishes in the first three
//   stages and rides along.
// Stall: the output register is backed by a one-entry skid stage. While the
//   receiver stalls, one more result is caught in the skid stage; then the
//   whole pipeline holds and req.ready drops until the skid stage drains.
// Reset: rst is synchronous, active high; it clears all valid bits, so no
//   request in flight survives. There is no configuration.
`include "ring_identifier_arithmetic_macros.svh"

module ring_identifier_arithmetic (
  input logic     clk,
  input logic     rst,
  ria_req_if.sink req,
  ria_res_if.source rsp
);
  import ria_pkg::*;

  logic                adv;
  logic [DIV_STAGES-1:0] vld;
  logic [ACT_BITS-1:0] act_q [DIV_STAGES];
  id_t                 a_q   [DIV_STAGES];
  num_t                mod_q [DIV_STAGES];
  num_t                rem_q [DIV_STAGES];
  num_t                rem_next [DIV_STAGES];
  res_t                res_q [3:DIV_STAGES-1];
  res_t                ops_res;

  res_t                last_res;
  res_t                o_res, s_res;
  logic                ovalid, svalid;

  assign adv       = !svalid;
  assign req.ready = adv;

  ria_ring_ops u_ops (
    .clk    (clk),
    .en     (adv),
    .action (req.action),
    .id_a   (req.id_a),
    .id_b   (req.id_b),
    .id_c   (req.id_c),
    .res    (ops_res)
  );

  always_comb begin
    rem_next[0] = div_step('0, req.id_a[ID_BITS-1], req.modulus);
    for (int k = 1; k < DIV_STAGES; k++) begin
      rem_next[k] = div_step(rem_q[k-1], a_q[k-1][ID_BITS-1-k], mod_q[k-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[DIV_STAGES-2:0], req.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      act_q[0] <= req.action;
      a_q[0]   <= req.id_a;
      mod_q[0] <= req.modulus;
      rem_q[0] <= rem_next[0];
      for (int k = 1; k < DIV_STAGES; k++) begin
        act_q[k] <= act_q[k-1];
        a_q[k]   <= a_q[k-1];
        mod_q[k] <= mod_q[k-1];
        rem_q[k] <= rem_next[k];
      end
      res_q[3] <= ops_res;
      for (int k = 4; k < DIV_STAGES; k++) begin
        res_q[k] <= res_q[k-1];
      end
    end
  end

  // merge the remainder in; a zero divisor gives zero
  always_comb begin
    last_res = res_q[DIV_STAGES-1];
    if (act_q[DIV_STAGES-1] == ACT_MODULO) begin
      last_res.num = (mod_q[DIV_STAGES-1] == '0) ? '0 : rem_q[DIV_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
      svalid <= 1'b0;
    end else if (rsp.ready || !ovalid) begin
      ovalid <= svalid || vld[DIV_STAGES-1];
      svalid <= 1'b0;
    end else if (vld[DIV_STAGES-1]) begin
      // receiver stalled: catch the last stage's request in the skid stage
      svalid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp.ready || !ovalid) begin
      o_res <= svalid ? s_res : last_res;
    end else if (adv) begin
      s_res <= last_res;
    end
  end

  assign rsp.valid         = ovalid;
  assign rsp.answer_flag   = o_res.flag;
  assign rsp.answer_id     = o_res.id;
  assign rsp.answer_number = o_res.num;

  `RIA_ASSERT_IMP(a_skid_needs_out, svalid, ovalid, "skid stage full with output empty")
  `RIA_ASSERT_NXT(a_stall_holds_skid, svalid && ovalid && !rsp.ready, svalid,
                  "skid stage lost a request under stall")
  `RIA_ASSERT_IMP(a_rem_below_mod,
                  vld[DIV_STAGES-1] && act_q[DIV_STAGES-1] == ACT_MODULO &&
                  mod_q[DIV_STAGES-1] != '0,
                  rem_q[DIV_STAGES-1] < mod_q[DIV_STAGES-1], "remainder not below divisor")

endmodule
